// ===== design/pqph_pkg.sv =====
// Shared types, constants and helpers for the priority queue / probing hash core.
// Used by pqph_queue, pqph_table and priority_queue_to_probing_hash_core.
package pqph_pkg;

  // Sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int TABLE_SLOTS = 10;
  localparam int NUM_PRIO    = 4;

  localparam int QAW     = $clog2(QUEUE_DEPTH);
  localparam int CNTW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SW      = $clog2(TABLE_SLOTS);
  localparam int PW      = 2;
  localparam int IDW     = 16;
  localparam int SLOT_FW = 4;
  localparam int LVL_W   = 5;
  localparam int LVL_MAX = (2 ** LVL_W) - 1;
  localparam int IN_DW   = 24;
  localparam int OUT_DW  = 32;
  localparam int OP_W    = 2;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_PROC = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_DROP  = 2'd3
  } status_e;

  // Queue control and status
  typedef struct packed {
    logic          push;
    logic          pop;
    logic [PW-1:0] prio;
  } q_ctrl_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic [PW-1:0]   head_prio;
    logic [CNTW-1:0] count;
  } q_stat_t;

  // Table control
  typedef struct packed {
    logic          wr;
    logic [SW-1:0] widx;
    logic [SW-1:0] ridx;
  } t_ctrl_t;

  // One result before the level is attached
  typedef struct packed {
    status_e            status;
    logic [IDW-1:0]     id;
    logic [PW-1:0]      prio;
    logic [SLOT_FW-1:0] slot;
    logic               valid;
  } res_t;

  // Priority class from the two flags
  function automatic logic [PW-1:0] prio_of(logic imp, logic lik);
    logic [PW-1:0] p;
    p = {imp, lik};
    return p;
  endfunction

  // Advance a ring pointer with wrap at the queue depth
  function automatic logic [QAW-1:0] qptr_inc(logic [QAW-1:0] p);
    logic [QAW-1:0] n;
    n = (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  // Saturate the queue count into the level field
  function automatic logic [LVL_W-1:0] lvl_sat(logic [CNTW-1:0] c);
    logic [LVL_W-1:0] l;
    if (int'(c) > LVL_MAX) begin
      l = LVL_W'(LVL_MAX);
    end else begin
      l = LVL_W'(c);
    end
    return l;
  endfunction

endpackage

// ===== design/pqph_queue.sv =====
// Priority queue kept as one FIFO ring per priority class in a single memory.
// Depends on pqph_pkg for sizing, pointer helpers and control/status structs.
module pqph_queue import pqph_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  q_ctrl_t        ctrl_i,
  input  logic [IDW-1:0] wid_i,
  output logic [IDW-1:0] rid_o,
  output q_stat_t        stat_o
);

  logic [IDW-1:0]  qmem [NUM_PRIO * (2 ** QAW)];
  logic [QAW-1:0]  head_q [NUM_PRIO];
  logic [QAW-1:0]  tail_q [NUM_PRIO];
  logic [CNTW-1:0] cnt_q  [NUM_PRIO];
  logic [CNTW-1:0] count_q;
  logic [IDW-1:0]  rid_q;
  logic [PW-1:0]   head_prio;
  logic [CNTW+1:0] cnt_sum;

  // Pick the highest nonempty class as head
  always_comb begin
    head_prio = '0;
    for (int p = 0; p < NUM_PRIO; p++) begin
      if (cnt_q[p] != '0) begin
        head_prio = PW'(p);
      end
    end
  end

  assign cnt_sum = {2'b00, cnt_q[0]} + {2'b00, cnt_q[1]} + {2'b00, cnt_q[2]} + {2'b00, cnt_q[3]};

  // Advance ring pointers and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PRIO; p++) begin
        head_q[p] <= '0;
        tail_q[p] <= '0;
        cnt_q[p]  <= '0;
      end
      count_q <= '0;
    end else begin
      for (int p = 0; p < NUM_PRIO; p++) begin
        if (ctrl_i.push && (ctrl_i.prio == PW'(p))) begin
          tail_q[p] <= qptr_inc(tail_q[p]);
          cnt_q[p]  <= cnt_q[p] + 1'b1;
        end
        if (ctrl_i.pop && (head_prio == PW'(p))) begin
          head_q[p] <= qptr_inc(head_q[p]);
          cnt_q[p]  <= cnt_q[p] - 1'b1;
        end
      end
      if (ctrl_i.push) begin
        count_q <= count_q + 1'b1;
      end else if (ctrl_i.pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Write the new entry at the tail, read the head on pop
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      qmem[{ctrl_i.prio, tail_q[ctrl_i.prio]}] <= wid_i;
    end
    if (ctrl_i.pop) begin
      rid_q <= qmem[{head_prio, head_q[head_prio]}];
    end
  end

  assign rid_o            = rid_q;
  assign stat_o.full      = (count_q == CNTW'(QUEUE_DEPTH));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.head_prio = head_prio;
  assign stat_o.count     = count_q;

  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_sum == {2'b00, count_q})
    else $error("queue total disagrees with per-class counts");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> (count_q != '0))
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |=> (count_q <= CNTW'(QUEUE_DEPTH)) && !$past(ctrl_i.pop))
    else $error("push overflow or push with pop");

endmodule

// ===== design/pqph_table.sv =====
// Hash slot table: slot ids in a synchronous memory, occupancy in flops.
// Depends on pqph_pkg for sizing and the table control struct.
module pqph_table import pqph_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  t_ctrl_t                ctrl_i,
  input  logic [IDW-1:0]         wid_i,
  output logic [IDW-1:0]         rid_o,
  output logic [TABLE_SLOTS-1:0] used_o
);

  logic [IDW-1:0]         tmem [TABLE_SLOTS];
  logic [IDW-1:0]         rid_q;
  logic [TABLE_SLOTS-1:0] used_q;

  // Mark slots occupied on store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (ctrl_i.wr) begin
      used_q[ctrl_i.widx] <= 1'b1;
    end
  end

  // Store and read slot ids
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      tmem[ctrl_i.widx] <= wid_i;
    end
    rid_q <= tmem[ctrl_i.ridx];
  end

  assign rid_o  = rid_q;
  assign used_o = used_q;

  a_store_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.wr |-> !used_q[ctrl_i.widx])
    else $error("store into occupied slot");

endmodule

// ===== design/priority_queue_to_probing_hash_core.sv =====
// Priority queue feeding a linear-probing hash table, one result per request.
// Sequence: add and unused op go from dispatch to done, read passes a slot read; process
// reads the head, takes id mod slots by reciprocal, then probes 1..TABLE_SLOTS slots.
// One request is in flight at a time; the next is accepted once the result is queued.
// Reset (rst_ni low, async) empties the queue and clears all slot valid bits.
module priority_queue_to_probing_hash_core import pqph_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [15:0] id, [16] impact, [17] likelihood, [21:18] slot_sel, [23:22] zero
  input  logic [IN_DW-1:0]  s_axis_tdata_i,
  // [1:0] op
  input  logic [OP_W-1:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // [1:0] status, [17:2] out_id, [19:18] out_priority, [23:20] out_slot,
  // [24] slot_valid, [29:25] queue_level, [31:30] zero
  output logic [OUT_DW-1:0] m_axis_tdata_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DISP   = 7'b0000010,
    S_HEAD   = 7'b0000100,
    S_MOD    = 7'b0001000,
    S_PROBE  = 7'b0010000,
    S_RDSLOT = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  // Reciprocal of the slot count, exact for every id below 2**IDW
  localparam int RECIP_SH = IDW + SW;
  localparam int PROD_W   = IDW + RECIP_SH;
  localparam logic [RECIP_SH-1:0] RECIP =
    RECIP_SH'(((1 << RECIP_SH) + TABLE_SLOTS - 1) / TABLE_SLOTS);

  state_e              state_q, state_d;
  logic                ovalid_q, ovalid_d;
  op_e                 op_q, op_d;
  logic [IDW-1:0]      id_q, id_d;
  logic [PW-1:0]       prio_q, prio_d;
  logic [SLOT_FW-1:0]  sel_q, sel_d;
  logic [IDW-1:0]      quo_q, quo_d;
  logic                step_q, step_d;
  logic [SW-1:0]       idx_q, idx_d;
  res_t                res_q, res_d;
  logic [OUT_DW-1:0]   out_q, out_d;

  q_ctrl_t                q_ctrl;
  q_stat_t                q_stat;
  logic [IDW-1:0]         q_rid;
  t_ctrl_t                t_ctrl;
  logic [IDW-1:0]         t_rid;
  logic [TABLE_SLOTS-1:0] t_used;

  logic [PROD_W-1:0] quo_prod;
  logic [IDW-1:0]    quo_mul;
  logic [IDW-1:0]    rem_full;
  logic              all_used;
  logic              sel_in_range;
  logic              probe_hit;

  pqph_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (q_ctrl),
    .wid_i  (id_q),
    .rid_o  (q_rid),
    .stat_o (q_stat)
  );

  pqph_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (t_ctrl),
    .wid_i  (id_q),
    .rid_o  (t_rid),
    .used_o (t_used)
  );

  // Quotient by reciprocal multiply, then remainder from the registered quotient
  assign quo_prod = {{RECIP_SH{1'b0}}, id_q} * {{IDW{1'b0}}, RECIP};
  assign quo_mul  = quo_q * IDW'(TABLE_SLOTS);
  assign rem_full = id_q - quo_mul;

  assign all_used     = &t_used;
  assign probe_hit    = !t_used[idx_q];
  assign sel_in_range = ({1'b0, sel_q} < (SLOT_FW+1)'(TABLE_SLOTS));

  // Drive queue and table ports
  always_comb begin
    q_ctrl.push = (state_q == S_DISP) && (op_q == OP_ADD) && !q_stat.full;
    q_ctrl.pop  = (state_q == S_DISP) && (op_q == OP_PROC) && !q_stat.empty;
    q_ctrl.prio = prio_q;
    t_ctrl.wr   = (state_q == S_PROBE) && !all_used && probe_hit;
    t_ctrl.widx = idx_q;
    t_ctrl.ridx = sel_q[SW-1:0];
  end

  assign s_axis_tready_o = (state_q == S_IDLE);

  // Sequence one request
  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    op_d     = op_q;
    id_d     = id_q;
    prio_d   = prio_q;
    sel_d    = sel_q;
    quo_d    = quo_q;
    step_d   = step_q;
    idx_d    = idx_q;
    res_d    = res_q;
    out_d    = out_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d    = op_e'(s_axis_tuser_i);
          id_d    = s_axis_tdata_i[15:0];
          prio_d  = prio_of(s_axis_tdata_i[16], s_axis_tdata_i[17]);
          sel_d   = s_axis_tdata_i[21:18];
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        res_d = '{status: ST_OK, id: '0, prio: '0, slot: '0, valid: 1'b0};
        case (op_q)
          OP_ADD: begin
            res_d.status = q_stat.full ? ST_FULL : ST_OK;
            res_d.id     = id_q;
            res_d.prio   = prio_q;
            state_d      = S_DONE;
          end
          OP_PROC: begin
            if (q_stat.empty) begin
              res_d.status = ST_EMPTY;
              state_d      = S_DONE;
            end else begin
              prio_d  = q_stat.head_prio;
              state_d = S_HEAD;
            end
          end
          OP_READ: begin
            state_d = S_RDSLOT;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_HEAD: begin
        id_d    = q_rid;
        step_d  = 1'b0;
        state_d = S_MOD;
      end
      S_MOD: begin
        if (!step_q) begin
          quo_d  = quo_prod[PROD_W-1 -: IDW];
          step_d = 1'b1;
        end else begin
          idx_d   = rem_full[SW-1:0];
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        res_d.id    = id_q;
        res_d.prio  = prio_q;
        res_d.valid = 1'b0;
        if (all_used) begin
          res_d.status = ST_DROP;
          res_d.slot   = '0;
          state_d      = S_DONE;
        end else if (probe_hit) begin
          res_d.status = ST_OK;
          res_d.slot   = SLOT_FW'(idx_q);
          state_d      = S_DONE;
        end else begin
          idx_d = (idx_q == SW'(TABLE_SLOTS - 1)) ? '0 : idx_q + 1'b1;
        end
      end
      S_RDSLOT: begin
        res_d.status = ST_OK;
        res_d.prio   = '0;
        res_d.slot   = sel_q;
        res_d.valid  = sel_in_range && t_used[sel_q[SW-1:0]];
        res_d.id     = res_d.valid ? t_rid : '0;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q || m_axis_tready_i) begin
          out_d = {2'b00, lvl_sat(q_stat.count), res_q.valid, res_q.slot,
                   res_q.prio, res_q.id, res_q.status};
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    id_q   <= id_d;
    prio_q <= prio_d;
    sel_q  <= sel_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = out_q;

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == S_DONE))
    else $error("result presented outside of completion");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> ({1'b0, idx_q} < (SW+1)'(TABLE_SLOTS)))
    else $error("probe index beyond slot count");

endmodule
